// ===== rtl/pbc_pkg.sv =====
`timescale 1ns / 1ps

package pbc_pkg;

  // default sizes of the tap store and of the largest block
  localparam int MAX_TAPS_DEF  = 4096;
  localparam int MAX_BLOCK_DEF = 64;

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 12;
  localparam int SAMPLE_W = 16;
  localparam int TAPV_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int STORE_W  = 20;
  localparam int KLEN_W   = 13;
  localparam int BSL2_W   = 3;
  localparam int TPROD_W  = TAPV_W + GAIN_W;
  localparam int PROD_W   = STORE_W + SAMPLE_W;

  // configuration port
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  // reset values of the registers
  localparam logic [KLEN_W-1:0]        KLEN_RST = '0;
  localparam logic [BSL2_W-1:0]        BSL2_RST = 3'd6;
  localparam logic signed [GAIN_W-1:0] GAIN_RST = 16'sd4096;

  // rounding and saturation
  localparam int TAP_SHIFT = 12;
  localparam int TAP_ROUND = 2048;
  localparam int OUT_SHIFT = 15;
  localparam int OUT_ROUND = 16384;
  localparam int STORE_MAX = 524287;
  localparam int STORE_MIN = -524288;
  localparam int OUT_MAX   = 32767;
  localparam int OUT_MIN   = -32768;

  // unity tap in Q5.15, used for pass-through
  localparam logic signed [STORE_W-1:0] UNIT_TAP = 20'sd32768;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_KLEN = 2'd0,
    REG_BSL2 = 2'd1,
    REG_GAIN = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAPW,
    ST_START,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [KLEN_W-1:0]        kernel_length;
    logic [BSL2_W-1:0]        block_size_log2;
    logic signed [GAIN_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic hist_write;
    logic clear;
    logic tap_mul;
    logic tap_write;
    logic out_start;
    logic mac_issue;
    logic mac_first;
    logic mac_pass;
    logic out_load;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/pbc_if.sv =====
`timescale 1ns / 1ps

// input item channel
interface pbc_in_if;
  import pbc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [INDEX_W-1:0]         tap_index;
  logic signed [TAPV_W-1:0]   tap_value;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output action, output tap_index, output tap_value,
                  output sample, input ready);
  modport sink   (input valid, input action, input tap_index, input tap_value,
                  input sample, output ready);
endinterface

// result item channel
interface pbc_out_if;
  import pbc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       block_last;

  modport source (output valid, output out_sample, output block_last, input ready);
  modport sink   (input valid, input out_sample, input block_last, output ready);
endinterface

// ===== rtl/pbc_cfg.sv =====
`timescale 1ns / 1ps

module pbc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbc_pkg::PADDR_W-1:0]  paddr,
  input  logic [pbc_pkg::PDATA_W-1:0]  pwdata,
  output logic [pbc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output pbc_pkg::cfg_t                cfg_o
);
  import pbc_pkg::*;

  logic [KLEN_W-1:0]        klen_q;
  logic [BSL2_W-1:0]        bsl2_q;
  logic signed [GAIN_W-1:0] gain_q;
  logic                     wr_en;
  reg_e                     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_e'(paddr[PADDR_W-1:2]);

  // register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= KLEN_RST;
      bsl2_q <= BSL2_RST;
      gain_q <= GAIN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KLEN: klen_q <= pwdata[KLEN_W-1:0];
        REG_BSL2: bsl2_q <= pwdata[BSL2_W-1:0];
        REG_GAIN: gain_q <= pwdata[GAIN_W-1:0];
        default:  ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_KLEN: prdata = PDATA_W'(klen_q);
      REG_BSL2: prdata = PDATA_W'(bsl2_q);
      REG_GAIN: prdata = PDATA_W'(gain_q);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o.kernel_length   = klen_q;
  assign cfg_o.block_size_log2 = bsl2_q;
  assign cfg_o.gain            = gain_q;

endmodule

// ===== rtl/pbc_dp.sv =====
`timescale 1ns / 1ps

module pbc_dp #(
  parameter int  MAX_TAPS  = pbc_pkg::MAX_TAPS_DEF,
  parameter int  MAX_BLOCK = pbc_pkg::MAX_BLOCK_DEF,
  localparam int AGE_W     = $clog2(MAX_TAPS + MAX_BLOCK + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pbc_pkg::cmd_t                         cmd_i,
  input  logic [AGE_W-1:0]                      age_i,
  input  logic [pbc_pkg::KLEN_W-1:0]            k_i,
  input  logic signed [pbc_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic [pbc_pkg::INDEX_W-1:0]           tap_index_i,
  input  logic signed [pbc_pkg::TAPV_W-1:0]     tap_value_i,
  input  logic signed [pbc_pkg::GAIN_W-1:0]     gain_i,
  input  logic                                  out_ready_i,
  output pbc_pkg::sts_t                         sts_o,
  output logic                                  out_valid_o,
  output logic signed [pbc_pkg::SAMPLE_W-1:0]   out_sample_o,
  output logic                                  block_last_o
);
  import pbc_pkg::*;

  localparam int HIST_D  = MAX_TAPS + MAX_BLOCK;
  localparam int HIST_AW = $clog2(HIST_D);
  localparam int TAP_AW  = (MAX_TAPS > 2) ? $clog2(MAX_TAPS) : 1;
  localparam int ACC_W   = PROD_W + $clog2(MAX_TAPS) + 1;

  // storage
  logic signed [STORE_W-1:0]  tap_mem  [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_mem [HIST_D];

  // history write side
  logic [HIST_AW-1:0] ptr_q;
  logic [AGE_W-1:0]   cnt_q;
  logic [HIST_AW-1:0] ptr_inc;

  // tap scaling
  logic signed [TPROD_W-1:0] tprod_q;
  logic [TAP_AW-1:0]         taddr_q;
  logic                      tok_q;
  logic [31:0]               tidx_ext;
  logic signed [TPROD_W:0]   tround;
  logic signed [TPROD_W:0]   tshift;
  logic signed [STORE_W-1:0] tap_sat;

  // read address generation
  logic [AGE_W-1:0]   age_q;
  logic [HIST_AW-1:0] haddr_q;
  logic [31:0]        hstart;
  logic [HIST_AW-1:0] hdec;
  logic [31:0]        k_ext;
  logic [TAP_AW-1:0]  tap_raddr;

  // mac pipeline
  logic                       v1_q, v2_q;
  logic                       first1_q, zero1_q, pass1_q, first2_q;
  logic signed [STORE_W-1:0]  tap_rd_q;
  logic signed [SAMPLE_W-1:0] hist_rd_q;
  logic signed [STORE_W-1:0]  tap_op;
  logic signed [SAMPLE_W-1:0] samp_op;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;

  // output rounding and register
  logic signed [ACC_W:0]      rnd;
  logic signed [ACC_W:0]      rsh;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       block_last_q;

  // history pointer and count of written entries since clear
  assign ptr_inc = (32'(ptr_q) == HIST_D - 1) ? '0 : ptr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.clear) begin
      ptr_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.hist_write) begin
      ptr_q <= ptr_inc;
      if (32'(cnt_q) != HIST_D) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // tap product, registered before rounding
  assign tidx_ext = 32'(tap_index_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_mul) begin
      tprod_q <= tap_value_i * gain_i;
      taddr_q <= tidx_ext[TAP_AW-1:0];
      tok_q   <= (tidx_ext < 32'(MAX_TAPS));
    end
  end

  // round half up and saturate to the store width
  always_comb begin
    tround = (TPROD_W+1)'(tprod_q) + (TPROD_W+1)'(TAP_ROUND);
    tshift = tround >>> TAP_SHIFT;
    if (tshift > (TPROD_W+1)'(STORE_MAX)) begin
      tap_sat = STORE_W'(STORE_MAX);
    end else if (tshift < (TPROD_W+1)'(STORE_MIN)) begin
      tap_sat = STORE_W'(STORE_MIN);
    end else begin
      tap_sat = tshift[STORE_W-1:0];
    end
  end

  // read addresses: history walks backwards from the output position
  assign hstart = 32'(ptr_q) + ((32'(age_i) > 32'(ptr_q)) ? 32'(HIST_D) : 32'd0)
                  - 32'(age_i);
  assign hdec   = (haddr_q == '0) ? HIST_AW'(HIST_D - 1) : haddr_q - 1'b1;
  assign k_ext  = 32'(k_i);
  assign tap_raddr = k_ext[TAP_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_start) begin
      age_q   <= age_i;
      haddr_q <= hstart[HIST_AW-1:0];
    end else if (cmd_i.mac_issue) begin
      age_q   <= age_q + 1'b1;
      haddr_q <= hdec;
    end
  end

  // tap store
  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_write && tok_q) begin
      tap_mem[taddr_q] <= tap_sat;
    end
    if (cmd_i.mac_issue) begin
      tap_rd_q <= tap_mem[tap_raddr];
    end
  end

  // sample history
  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_write) begin
      hist_mem[ptr_q] <= sample_i;
    end
    if (cmd_i.mac_issue) begin
      hist_rd_q <= hist_mem[haddr_q];
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end

  // entries older than the written count read as zero
  assign tap_op  = pass1_q ? UNIT_TAP : tap_rd_q;
  assign samp_op = zero1_q ? '0 : hist_rd_q;

  // read stage flags, multiply, accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_issue) begin
      first1_q <= cmd_i.mac_first;
      pass1_q  <= cmd_i.mac_pass;
      zero1_q  <= (age_q > cnt_q);
    end
    if (v1_q) begin
      prod_q   <= tap_op * samp_op;
      first2_q <= first1_q;
    end
    if (v2_q) begin
      acc_q <= (first2_q ? '0 : acc_q) + ACC_W'(prod_q);
    end
  end

  // output rounding and saturation
  always_comb begin
    rnd = (ACC_W+1)'(acc_q) + (ACC_W+1)'(OUT_ROUND);
    rsh = rnd >>> OUT_SHIFT;
    if (rsh > (ACC_W+1)'(OUT_MAX)) begin
      y_sat = SAMPLE_W'(OUT_MAX);
    end else if (rsh < (ACC_W+1)'(OUT_MIN)) begin
      y_sat = SAMPLE_W'(OUT_MIN);
    end else begin
      y_sat = rsh[SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_sample_q <= y_sat;
      block_last_q <= cmd_i.out_last;
    end
  end

  assign sts_o.busy     = v1_q || v2_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_sample_o   = out_sample_q;
  assign block_last_o   = block_last_q;

`ifndef ASSERT_OFF
  a_pipe_flow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |=> v2_q)
    else $error("mac read stage did not reach the multiply stage");

  a_age_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mac_issue |-> (32'(age_q) < HIST_D))
    else $error("history read reaches beyond the stored depth");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= HIST_D)
    else $error("written count exceeds history depth");
`endif

endmodule

// ===== rtl/pbc_ctrl.sv =====
`timescale 1ns / 1ps

module pbc_ctrl #(
  parameter int  MAX_TAPS  = pbc_pkg::MAX_TAPS_DEF,
  parameter int  MAX_BLOCK = pbc_pkg::MAX_BLOCK_DEF,
  localparam int AGE_W     = $clog2(MAX_TAPS + MAX_BLOCK + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pbc_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  input  logic [pbc_pkg::ACTION_W-1:0]  in_action_i,
  output logic                          in_ready_o,
  input  pbc_pkg::sts_t                 sts_i,
  output pbc_pkg::cmd_t                 cmd_o,
  output logic [AGE_W-1:0]              age_o,
  output logic [pbc_pkg::KLEN_W-1:0]    k_o
);
  import pbc_pkg::*;

  localparam int FILL_W = $clog2(MAX_BLOCK + 1);

  state_e            state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] oidx_q, oidx_d;
  logic [KLEN_W-1:0] k_q, k_d;

  logic              in_xfer;
  action_e           act;
  logic [FILL_W-1:0] fill_inc;
  logic [FILL_W-1:0] age_start;
  logic [31:0]       lg, bs_raw, bs32, len32;
  logic              pass;
  logic [KLEN_W-1:0] last_k;
  logic              last_out;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign act        = action_e'(in_action_i);

  // effective block size and kernel length
  assign lg     = (cfg_i.block_size_log2 < BSL2_W'(1)) ? 32'd1 : 32'(cfg_i.block_size_log2);
  assign bs_raw = 32'd1 << lg;
  assign bs32   = (bs_raw > 32'(MAX_BLOCK)) ? 32'(MAX_BLOCK) : bs_raw;
  assign len32  = (32'(cfg_i.kernel_length) > 32'(MAX_TAPS)) ? 32'(MAX_TAPS)
                                                             : 32'(cfg_i.kernel_length);
  assign pass   = (len32 < 32'd2);
  assign last_k = pass ? '0 : KLEN_W'(len32 - 32'd1);

  assign fill_inc  = fill_q + 1'b1;
  assign age_start = fill_q - oidx_q;
  assign last_out  = ((32'(oidx_q) + 32'd1) == 32'(fill_q));

  // next state and counters
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    oidx_d  = oidx_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (act)
            ACT_SAMPLE: begin
              fill_d = fill_inc;
              if (32'(fill_inc) >= bs32) begin
                oidx_d  = '0;
                state_d = ST_START;
              end
            end
            ACT_LOAD:  state_d = ST_TAPW;
            ACT_CLEAR: fill_d  = '0;
            default:   ;
          endcase
        end
      end
      ST_TAPW:  state_d = ST_IDLE;
      ST_START: begin
        k_d     = '0;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        if (k_q == last_k) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          if (last_out) begin
            fill_d  = '0;
            state_d = ST_IDLE;
          end else begin
            oidx_d  = oidx_q + 1'b1;
            state_d = ST_START;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    age_o = AGE_W'(age_start);
    k_o   = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (act)
            ACT_SAMPLE: cmd_o.hist_write = 1'b1;
            ACT_LOAD:   cmd_o.tap_mul    = 1'b1;
            ACT_CLEAR:  cmd_o.clear      = 1'b1;
            default:    ;
          endcase
        end
      end
      ST_TAPW:  cmd_o.tap_write = 1'b1;
      ST_START: cmd_o.out_start = 1'b1;
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.mac_first = (k_q == '0);
        cmd_o.mac_pass  = pass;
      end
      ST_DRAIN: ;
      ST_FINISH: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_last = last_out;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      oidx_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      oidx_q  <= oidx_d;
      k_q     <= k_d;
    end
  end

`ifndef ASSERT_OFF
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("output register loaded while still occupied");

  a_finish_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> !sts_i.busy)
    else $error("result taken before the mac pipeline drained");

  a_fill_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= MAX_BLOCK)
    else $error("block fill exceeds the largest block");

  a_tap_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (k_q <= last_k))
    else $error("tap counter ran past the kernel length");
`endif

endmodule

// ===== rtl/partitioned_block_convolver.sv =====
`timescale 1ns / 1ps

// Block FIR convolver: samples gather into blocks of 2^block_size_log2 (at least
// 2, at most MAX_BLOCK); the sample that completes a block starts one result per
// block sample, each the rounded, saturated Q1.15 sum of kernel_length (at most
// MAX_TAPS) products of stored taps (tap*gain in Q5.15, scaled on load) with the
// sample history, the last result of the block flagged; a kernel_length below 2
// passes the sample through. A sample that does not complete a block and a clear
// are taken in the idle state; a tap load also passes a tap-write state. For each
// output a start state comes first; then one shared multiply-accumulate unit fed
// by a single read port on the tap store and on the history memory walks one tap
// per cycle; then the pipeline drains and a result state loads the output register
// once it is free. Input is taken again once the last result of a block sits in
// the output register. There is no clearing pass after reset: a count of samples
// written since reset or clear makes older history read as zero. Taps that were never loaded read as undefined.
module partitioned_block_convolver #(
  parameter int MAX_TAPS  = pbc_pkg::MAX_TAPS_DEF,
  parameter int MAX_BLOCK = pbc_pkg::MAX_BLOCK_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pbc_in_if.sink                       in_i,
  pbc_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbc_pkg::PADDR_W-1:0]  paddr,
  input  logic [pbc_pkg::PDATA_W-1:0]  pwdata,
  output logic [pbc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import pbc_pkg::*;

  localparam int AGE_W = $clog2(MAX_TAPS + MAX_BLOCK + 1);

  cfg_t              cfg;
  cmd_t              cmd;
  sts_t              sts;
  logic [AGE_W-1:0]  age;
  logic [KLEN_W-1:0] k;
  logic              in_ready;

  // configuration registers
  pbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer
  pbc_ctrl #(
    .MAX_TAPS  (MAX_TAPS),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .age_o       (age),
    .k_o         (k)
  );

  assign in_i.ready = in_ready;

  // storage, mac and output register
  pbc_dp #(
    .MAX_TAPS  (MAX_TAPS),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .age_i        (age),
    .k_i          (k),
    .sample_i     (in_i.sample),
    .tap_index_i  (in_i.tap_index),
    .tap_value_i  (in_i.tap_value),
    .gain_i       (cfg.gain),
    .out_ready_i  (out_o.ready),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .out_sample_o (out_o.out_sample),
    .block_last_o (out_o.block_last)
  );

endmodule
